>>> sv/bdq_pkg.sv
// Shared types and constants for the bounded deque core.
`default_nettype none

package bdq_pkg;

    localparam int OPC_BITS   = 3;
    localparam int CAP_BITS   = 11;
    localparam int FIELD_BITS = 32;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [OPC_BITS-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_PEEK       = 3'd4
    } bdq_op_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_LOAD = 4'b1000
    } bdq_state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the incoming item
        logic exec;      // apply the operation, write the store
        logic load_out;  // load the result register
    } bdq_cmd_t;

endpackage

`default_nettype wire

>>> sv/bdq_ram.sv
// Generic single-write, dual-read RAM with registered read data.
`default_nettype none

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

>>> sv/bdq_ctrl.sv
// Controller state machine: sequences each item and owns the handshakes.
`default_nettype none

module bdq_ctrl
    import bdq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output bdq_cmd_t  cmd
);

    bdq_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd.capture  = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/bdq_dp.sv
// Datapath: capacity register, ring pointers, store and result register.
`default_nettype none

module bdq_dp
    import bdq_pkg::*;
#(
    parameter int STORE_DEPTH = 1024,
    parameter int WORD_BITS   = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire bdq_cmd_t                     cmd,
    input  wire logic                         cfg_we,
    input  wire logic [CAP_BITS-1:0]          cfg_data,
    input  wire logic [OPC_BITS-1:0]          opcode,
    input  wire logic signed [FIELD_BITS-1:0] push_value,
    output logic                              accepted,
    output logic signed [FIELD_BITS-1:0]      front_value,
    output logic signed [FIELD_BITS-1:0]      rear_value,
    output logic                              is_empty,
    output logic                              is_full,
    output logic [CAP_BITS-1:0]               entry_count
);

    localparam int PTR_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX   = PTR_W'(STORE_DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_WIDE = (PTR_W + 1)'(STORE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(STORE_DEPTH);

    logic [CAP_BITS-1:0]  cap_reg;
    bdq_op_t              op_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [PTR_W-1:0]     front_reg, front_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 acc_reg, acc_next;

    logic [CNT_W-1:0]     eff_cap;
    logic                 full, empty;
    logic [CNT_W-1:0]     count_m1;
    logic [PTR_W:0]       tail_sum, rear_sum;
    logic [PTR_W-1:0]     tail_idx, rear_idx, front_dec, front_inc;

    logic                 we;
    logic [PTR_W-1:0]     waddr;
    logic [WORD_BITS-1:0] rdata_a, rdata_b;

    // capacity beyond the store saturates to the store depth
    assign eff_cap = (32'(cap_reg) > STORE_DEPTH) ? DEPTH_CNT : CNT_W'(cap_reg);
    assign full    = (count_reg >= eff_cap);
    assign empty   = (count_reg == '0);

    // ring index arithmetic, wrap by one conditional subtract
    assign count_m1  = count_reg - CNT_W'(1);
    assign tail_sum  = {1'b0, front_reg} + (PTR_W + 1)'(count_reg);
    assign rear_sum  = {1'b0, front_reg} + (PTR_W + 1)'(count_m1);
    assign tail_idx  = (tail_sum >= DEPTH_WIDE) ? PTR_W'(tail_sum - DEPTH_WIDE)
                                                : tail_sum[PTR_W-1:0];
    assign rear_idx  = (rear_sum >= DEPTH_WIDE) ? PTR_W'(rear_sum - DEPTH_WIDE)
                                                : rear_sum[PTR_W-1:0];
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - PTR_W'(1);
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + PTR_W'(1);

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        we         = 1'b0;
        waddr      = tail_idx;
        if (cmd.exec)
        begin
            acc_next = 1'b0;
            case (op_reg)
                OP_PUSH_FRONT:
                begin
                    if (!full)
                    begin
                        front_next = front_dec;
                        waddr      = front_dec;
                        we         = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        acc_next   = 1'b1;
                    end
                end
                OP_PUSH_REAR:
                begin
                    if (!full)
                    begin
                        we         = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        acc_next   = 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (!empty)
                    begin
                        front_next = front_inc;
                        count_next = count_m1;
                        acc_next   = 1'b1;
                    end
                end
                OP_POP_REAR:
                begin
                    if (!empty)
                    begin
                        count_next = count_m1;
                        acc_next   = 1'b1;
                    end
                end
                OP_PEEK:
                begin
                    acc_next = 1'b1;
                end
                default:
                begin
                    acc_next = 1'b0;
                end
            endcase
        end
    end

    bdq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (word_reg),
        .raddr_a (front_reg),
        .raddr_b (rear_idx),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            front_reg <= '0;
            count_reg <= '0;
            acc_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            front_reg <= front_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= bdq_op_t'(opcode);
            word_reg <= WORD_BITS'($unsigned(push_value));
        end
        if (cmd.load_out)
        begin
            accepted    <= acc_reg;
            front_value <= empty ? '1 : FIELD_BITS'(rdata_a);
            rear_value  <= empty ? '1 : FIELD_BITS'(rdata_b);
            is_empty    <= empty;
            is_full     <= full;
            entry_count <= CAP_BITS'(32'(count_reg));
        end
    end

endmodule

`default_nettype wire

>>> sv/bounded_double_ended_queue_core.sv
// Top level of the bounded deque core: a ring store of signed words.
//
// Input channel (in_valid/in_ready) carries opcode and push_value; a
// transfer happens on a clock edge with both high. Opcodes: push front,
// push rear, pop front, pop rear, peek. Other codes change nothing and
// report accepted = 0.
// Output channel (out_valid/out_ready) returns exactly one result per item:
// accepted, front/rear values after the step (all ones when empty), the
// empty and full flags and the entry count.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes the capacity; it is
// always ready. Write it only while the core is idle.
// Timing: an item runs execute, store read and result load in turn; its
// result is registered at the load. A new item is taken only after the
// last one has loaded. The store read step is there because the store's read port is registered.
// The result register holds a finished item while the receiver stalls; the
// next item may be taken meanwhile and then waits before loading.
// Reset: empty deque, capacity 1024, no result pending. Store contents are
// left as they are; only pushed entries are ever read.
`default_nettype none

module bounded_double_ended_queue_core
    import bdq_pkg::*;
#(
    parameter int STORE_DEPTH = 1024,
    parameter int WORD_BITS   = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [CAP_BITS-1:0]          cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [OPC_BITS-1:0]          opcode,
    input  wire logic signed [FIELD_BITS-1:0] push_value,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              accepted,
    output logic signed [FIELD_BITS-1:0]      front_value,
    output logic signed [FIELD_BITS-1:0]      rear_value,
    output logic                              is_empty,
    output logic                              is_full,
    output logic [CAP_BITS-1:0]               entry_count
);

    bdq_cmd_t cmd;

    // capacity register takes a write on any cycle
    assign cfg_ready = 1'b1;

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    bdq_dp #(
        .STORE_DEPTH (STORE_DEPTH),
        .WORD_BITS   (WORD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .opcode      (opcode),
        .push_value  (push_value),
        .accepted    (accepted),
        .front_value (front_value),
        .rear_value  (rear_value),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .entry_count (entry_count)
    );

    // one item in flight: after an input transfer the port closes
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on consecutive cycles");

    // empty flag agrees with the reported count
    a_empty_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    // an empty deque reports all-ones on both ends
    a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> (front_value == -1) && (rear_value == -1))
        else $error("empty deque reports a stored value");

endmodule

`default_nettype wire
